@@ rtl/core/clkrst_pkg.sv @@
// Package for the clock and reset control register file.
// Holds register offsets, reset values, the response type and the ready-bit helper.
// No dependencies; used by every other file of the block.
package clkrst_pkg;

    localparam int ADDR_W = 10;
    localparam int DATA_W = 32;
    localparam int BANK_W = 3;

    localparam logic [ADDR_W-1:0] OFF_CR     = 10'h000;
    localparam logic [ADDR_W-1:0] OFF_CFGR   = 10'h008;
    localparam logic [ADDR_W-1:0] OFF_RST_LO = 10'h010;
    localparam logic [ADDR_W-1:0] OFF_RST_HI = 10'h024;
    localparam logic [ADDR_W-1:0] OFF_ENR_LO = 10'h030;
    localparam logic [ADDR_W-1:0] OFF_ENR_HI = 10'h044;
    localparam logic [ADDR_W-1:0] OFF_BDCR   = 10'h070;
    localparam logic [ADDR_W-1:0] OFF_CSR    = 10'h074;

    localparam logic [DATA_W-1:0] CR_RESET_VALUE = 32'h0202_0002;
    localparam logic [DATA_W-1:0] SW_STATUS_BITS = 32'h0000_000C;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bad_offset;
        logic [DATA_W-1:0] reset_release_mask;
        logic [DATA_W-1:0] enable_rise_mask;
        logic [BANK_W-1:0] event_bank;
    } t_rsp;

    function automatic logic [DATA_W-1:0] ready_from_enable(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v;
        r[1]  = v[1]  | v[0];
        r[17] = v[17] | v[16];
        r[25] = v[25] | v[24];
        r[27] = v[27] | v[26];
        r[29] = v[29] | v[28];
        return r;
    endfunction

endpackage

@@ rtl/core/clkrst_if.sv @@
// Channel interfaces for the clock and reset control register file.
// Depends on clkrst_pkg for the field widths.
interface clkrst_req_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [clkrst_pkg::ADDR_W-1:0]   addr;
    logic [clkrst_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, func, addr, write_data, input ready);
    modport sink (input valid, func, addr, write_data, output ready);
endinterface

interface clkrst_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [clkrst_pkg::DATA_W-1:0]   read_data;
    logic                            bad_offset;
    logic [clkrst_pkg::DATA_W-1:0]   reset_release_mask;
    logic [clkrst_pkg::DATA_W-1:0]   enable_rise_mask;
    logic [clkrst_pkg::BANK_W-1:0]   event_bank;

    modport source (output valid, read_data, bad_offset, reset_release_mask,
                    enable_rise_mask, event_bank, input ready);
    modport sink (input valid, read_data, bad_offset, reset_release_mask,
                  enable_rise_mask, event_bank, output ready);
endinterface

@@ rtl/core/clkrst_regmem.sv @@
// Register storage: a synchronous memory with a registered read and per-entry valid bits.
// An entry never written reads as its reset value. Depends on clkrst_pkg.
module clkrst_regmem #(
    parameter int NUM_REGS = 38,
    parameter int IDX_W    = $clog2(NUM_REGS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [IDX_W-1:0]              i_rd_idx,
    input  logic                          i_wr_en,
    input  logic [IDX_W-1:0]              i_wr_idx,
    input  logic [clkrst_pkg::DATA_W-1:0] i_wr_data,
    output logic [clkrst_pkg::DATA_W-1:0] o_rd_data
);

    logic [clkrst_pkg::DATA_W-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]           r_valid;
    logic [clkrst_pkg::DATA_W-1:0] r_rd_word;
    logic                          r_rd_valid;
    logic                          r_rd_is_cr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_rd_is_cr <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
                r_rd_is_cr <= (i_rd_idx == '0);
            end
        end
    end

    always_comb begin
        if (r_rd_valid) begin
            o_rd_data = r_rd_word;
        end else if (r_rd_is_cr) begin
            o_rd_data = clkrst_pkg::CR_RESET_VALUE;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

@@ rtl/core/clkrst_update.sv @@
// Read-modify-write logic: decodes the offset, forms the new register word and the response.
// Depends on clkrst_pkg.
module clkrst_update #(
    parameter int NUM_REGS = 38
) (
    input  logic                            i_func,
    input  logic [clkrst_pkg::ADDR_W-1:0]   i_addr,
    input  logic [clkrst_pkg::DATA_W-1:0]   i_write_data,
    input  logic [clkrst_pkg::DATA_W-1:0]   i_cur_word,
    output logic                            o_wr_en,
    output logic [clkrst_pkg::DATA_W-1:0]   o_new_word,
    output clkrst_pkg::t_rsp                o_rsp
);

    localparam logic [clkrst_pkg::ADDR_W:0] LAST_OFF =
        (clkrst_pkg::ADDR_W + 1)'((NUM_REGS - 1) * 4);

    logic                          bad;
    logic [clkrst_pkg::ADDR_W-1:0] rst_rel;
    logic [clkrst_pkg::ADDR_W-1:0] enr_rel;

    assign bad     = {1'b0, i_addr} > LAST_OFF;
    assign rst_rel = i_addr - clkrst_pkg::OFF_RST_LO;
    assign enr_rel = i_addr - clkrst_pkg::OFF_ENR_LO;

    always_comb begin
        o_wr_en    = 1'b0;
        o_new_word = i_write_data;
        o_rsp      = '0;
        if (bad) begin
            o_rsp.bad_offset = 1'b1;
        end else if (i_func == clkrst_pkg::FUNC_READ) begin
            o_rsp.read_data = i_cur_word;
        end else begin
            o_wr_en = 1'b1;
            if (i_addr == clkrst_pkg::OFF_CR) begin
                o_new_word = clkrst_pkg::ready_from_enable(i_write_data);
            end else if (i_addr inside {[clkrst_pkg::OFF_RST_LO:clkrst_pkg::OFF_RST_HI]}) begin
                o_rsp.reset_release_mask = i_cur_word & ~i_write_data;
                o_rsp.event_bank         = rst_rel[4:2];
            end else if (i_addr inside {[clkrst_pkg::OFF_ENR_LO:clkrst_pkg::OFF_ENR_HI]}) begin
                o_rsp.enable_rise_mask = ~i_cur_word & i_write_data;
                o_rsp.event_bank       = enr_rel[4:2];
            end else if (i_addr == clkrst_pkg::OFF_BDCR || i_addr == clkrst_pkg::OFF_CSR) begin
                o_new_word    = i_write_data;
                o_new_word[1] = i_write_data[1] | i_write_data[0];
            end else if (i_addr == clkrst_pkg::OFF_CFGR) begin
                o_new_word = (i_write_data & ~clkrst_pkg::SW_STATUS_BITS)
                           | {28'd0, i_write_data[1:0], 2'b00};
            end
        end
    end

endmodule

@@ rtl/core/clock_reset_control_registers.sv @@
// Top level of the clock and reset control register file.
// Depends on clkrst_pkg, clkrst_if, clkrst_regmem and clkrst_update.
//
// A bus transaction is accepted only in the idle state. The register is read from the
// synchronous memory in the cycle after acceptance, then modified, written back and
// registered as the response; this waits while an earlier response is still untaken.
// A response waiting to be taken does not block the next acceptance. No clearing pass
// is needed after reset; unwritten registers read as their reset values.
module clock_reset_control_registers #(
    parameter int NUM_REGS = 38
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clkrst_req_if.sink  i_req,
    clkrst_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(NUM_REGS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                            r_state, n_state;
    logic                            r_func;
    logic [clkrst_pkg::ADDR_W-1:0]   r_addr;
    logic [clkrst_pkg::DATA_W-1:0]   r_wdata;
    logic                            r_out_valid, n_out_valid;
    clkrst_pkg::t_rsp                r_rsp;

    logic                            accept;
    logic                            finish;
    logic [clkrst_pkg::DATA_W-1:0]   cur_word;
    logic                            upd_wr_en;
    logic [clkrst_pkg::DATA_W-1:0]   new_word;
    clkrst_pkg::t_rsp                upd_rsp;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign finish      = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    clkrst_regmem #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_regmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_idx  (i_req.addr[IDX_W+1:2]),
        .i_wr_en   (finish && upd_wr_en),
        .i_wr_idx  (r_addr[IDX_W+1:2]),
        .i_wr_data (new_word),
        .o_rd_data (cur_word)
    );

    clkrst_update #(
        .NUM_REGS (NUM_REGS)
    ) u_update (
        .i_func       (r_func),
        .i_addr       (r_addr),
        .i_write_data (r_wdata),
        .i_cur_word   (cur_word),
        .o_wr_en      (upd_wr_en),
        .o_new_word   (new_word),
        .o_rsp        (upd_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (finish) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_req.func;
            r_addr  <= i_req.addr;
            r_wdata <= i_req.write_data;
        end
        if (finish) begin
            r_rsp <= upd_rsp;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.read_data          = r_rsp.read_data;
    assign o_rsp.bad_offset         = r_rsp.bad_offset;
    assign o_rsp.reset_release_mask = r_rsp.reset_release_mask;
    assign o_rsp.enable_rise_mask   = r_rsp.enable_rise_mask;
    assign o_rsp.event_bank         = r_rsp.event_bank;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the clock and reset control register file.
// Drives random bus reads and writes with random idling on both channels and checks every response.
// Depends on clkrst_pkg, clkrst_if and the clock_reset_control_registers top level.
module tb_top;
    import clkrst_pkg::*;

    localparam int NUM_REGS = 38;
    localparam logic [ADDR_W-1:0] LAST_OFF = ADDR_W'((NUM_REGS - 1) * 4);
    localparam int IDLE_LIMIT = 600;
    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_access;

    logic i_clk;
    logic i_rst_n;

    clkrst_req_if req_ch ();
    clkrst_rsp_if rsp_ch ();

    clock_reset_control_registers #(
        .NUM_REGS(NUM_REGS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    logic [DATA_W-1:0] reg_shadow [NUM_REGS];
    t_access           pending_accesses [$];
    t_rsp              expected_responses [$];
    int                error_count = 0;
    int                mismatch_count = 0;
    int                send_gap;
    int                ready_hold;
    int                idle_cycles;
    logic              calm_phase;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(10, 40);
        end
    endfunction

    // Applies one access to the shadow registers and returns the response it must produce.
    function automatic t_rsp apply_access(input t_access acc);
        t_rsp              rsp;
        logic [DATA_W-1:0] prev;
        logic [DATA_W-1:0] v;
        int                idx;
        rsp = '0;
        if (acc.addr > LAST_OFF) begin
            rsp.bad_offset = 1'b1;
        end else begin
            idx = int'(acc.addr >> 2);
            prev = reg_shadow[idx];
            v = acc.data;
            if (acc.func == FUNC_READ) begin
                rsp.read_data = prev;
            end else if (acc.addr == OFF_CR) begin
                if (v[0]) v[1] = 1'b1;
                if (v[16]) v[17] = 1'b1;
                if (v[24]) v[25] = 1'b1;
                if (v[26]) v[27] = 1'b1;
                if (v[28]) v[29] = 1'b1;
                reg_shadow[idx] = v;
            end else if (acc.addr >= OFF_RST_LO && acc.addr <= OFF_RST_HI) begin
                reg_shadow[idx] = v;
                rsp.reset_release_mask = prev & ~v;
                rsp.event_bank = BANK_W'((acc.addr - OFF_RST_LO) >> 2);
            end else if (acc.addr >= OFF_ENR_LO && acc.addr <= OFF_ENR_HI) begin
                reg_shadow[idx] = v;
                rsp.enable_rise_mask = ~prev & v;
                rsp.event_bank = BANK_W'((acc.addr - OFF_ENR_LO) >> 2);
            end else if (acc.addr == OFF_BDCR || acc.addr == OFF_CSR) begin
                if (v[0]) v[1] = 1'b1;
                reg_shadow[idx] = v;
            end else if (acc.addr == OFF_CFGR) begin
                v[3:2] = v[1:0];
                reg_shadow[idx] = v;
            end else begin
                reg_shadow[idx] = v;
            end
        end
        return rsp;
    endfunction

    function automatic t_access random_access();
        t_access acc;
        int      r;
        acc.func = ($urandom_range(0, 99) < 55) ? FUNC_WRITE : FUNC_READ;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 4))
                0: acc.addr = OFF_CR;
                1: acc.addr = OFF_CFGR;
                2: acc.addr = OFF_BDCR;
                3: acc.addr = OFF_CSR;
                default: acc.addr = OFF_CR + ADDR_W'($urandom_range(1, 3));
            endcase
        end else if (r < 30) begin
            acc.addr = OFF_RST_LO + ADDR_W'($urandom_range(0, 23));
        end else if (r < 45) begin
            acc.addr = OFF_ENR_LO + ADDR_W'($urandom_range(0, 23));
        end else if (r < 88) begin
            acc.addr = ADDR_W'($urandom_range(0, int'(LAST_OFF)));
        end else begin
            acc.addr = ADDR_W'($urandom_range(int'(LAST_OFF) + 1, 1023));
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            acc.data = '0;
        end else if (r < 10) begin
            acc.data = '1;
        end else begin
            acc.data = $urandom();
        end
        return acc;
    endfunction

    function automatic t_access mk(input logic func, input logic [ADDR_W-1:0] addr,
                                   input logic [DATA_W-1:0] data);
        t_access acc;
        acc.func = func;
        acc.addr = addr;
        acc.data = data;
        return acc;
    endfunction

    // Driver: presents queued transactions and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        t_access acc;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.func <= FUNC_READ;
            req_ch.addr <= '0;
            req_ch.write_data <= '0;
            send_gap <= 0;
            for (int k = 0; k < NUM_REGS; k++) begin
                reg_shadow[k] = '0;
            end
            reg_shadow[0] = CR_RESET_VALUE;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                acc = mk(req_ch.func, req_ch.addr, req_ch.write_data);
                expected_responses.push_back(apply_access(acc));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap != 0) begin
                    req_ch.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_accesses.size() != 0) begin
                    acc = pending_accesses.pop_front();
                    req_ch.func <= acc.func;
                    req_ch.addr <= acc.addr;
                    req_ch.write_data <= acc.data;
                    req_ch.valid <= 1'b1;
                    send_gap <= calm_phase ? 0 : pick_gap();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the response channel and compares each response with the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        t_rsp act_rsp;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            ready_hold <= 0;
            idle_cycles <= 0;
            calm_phase <= 1'b0;
        end else begin
            if ($urandom_range(0, 149) == 0) begin
                calm_phase <= ~calm_phase;
            end
            if (ready_hold != 0) begin
                rsp_ch.ready <= 1'b0;
                ready_hold <= ready_hold - 1;
            end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready <= 1'b0;
                ready_hold <= pick_gap();
            end else begin
                rsp_ch.ready <= 1'b1;
            end

            if (rsp_ch.valid && rsp_ch.ready) begin
                act_rsp.read_data = rsp_ch.read_data;
                act_rsp.bad_offset = rsp_ch.bad_offset;
                act_rsp.reset_release_mask = rsp_ch.reset_release_mask;
                act_rsp.enable_rise_mask = rsp_ch.enable_rise_mask;
                act_rsp.event_bank = rsp_ch.event_bank;
                if (expected_responses.size() == 0) begin
                    error_count++;
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("Unexpected response: rd=%h bad=%b rel=%h rise=%h bank=%0d",
                                 act_rsp.read_data, act_rsp.bad_offset,
                                 act_rsp.reset_release_mask, act_rsp.enable_rise_mask,
                                 act_rsp.event_bank);
                    end
                    mismatch_count++;
                end else begin
                    exp_rsp = expected_responses.pop_front();
                    if (act_rsp.read_data !== exp_rsp.read_data
                        || act_rsp.bad_offset !== exp_rsp.bad_offset
                        || act_rsp.reset_release_mask !== exp_rsp.reset_release_mask
                        || act_rsp.enable_rise_mask !== exp_rsp.enable_rise_mask
                        || act_rsp.event_bank !== exp_rsp.event_bank) begin
                        error_count++;
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("Mismatch: expected rd=%h bad=%b rel=%h rise=%h bank=%0d",
                                     exp_rsp.read_data, exp_rsp.bad_offset,
                                     exp_rsp.reset_release_mask, exp_rsp.enable_rise_mask,
                                     exp_rsp.event_bank);
                            $display("          actual   rd=%h bad=%b rel=%h rise=%h bank=%0d",
                                     act_rsp.read_data, act_rsp.bad_offset,
                                     act_rsp.reset_release_mask, act_rsp.enable_rise_mask,
                                     act_rsp.event_bank);
                        end
                        mismatch_count++;
                    end
                end
            end

            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("clock_reset_control_registers verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;

        pending_accesses.push_back(mk(FUNC_READ, OFF_CR, '0));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_CR, 32'h1501_0001));
        pending_accesses.push_back(mk(FUNC_READ, OFF_CR, '0));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_CR, '0));
        pending_accesses.push_back(mk(FUNC_READ, OFF_CR, '0));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_CR + 10'd1, 32'h1501_0001));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_CFGR, 32'hFFFF_FFF3));
        pending_accesses.push_back(mk(FUNC_READ, OFF_CFGR, '0));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_CFGR + 10'd2, 32'h0000_0003));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_RST_LO, '1));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_RST_LO, '0));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_RST_HI + 10'd3, 32'hA5A5_5A5A));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_RST_HI, 32'h0000_FFFF));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_ENR_LO, '1));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_ENR_HI + 10'd3, '1));
        pending_accesses.push_back(mk(FUNC_READ, OFF_ENR_HI, '0));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_BDCR, 32'h0000_0001));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_CSR, 32'hFFFF_FFFD));
        pending_accesses.push_back(mk(FUNC_WRITE, OFF_CSR + 10'd1, 32'h0000_0001));
        pending_accesses.push_back(mk(FUNC_READ, OFF_CSR, '0));
        pending_accesses.push_back(mk(FUNC_WRITE, LAST_OFF, 32'hDEAD_BEEF));
        pending_accesses.push_back(mk(FUNC_READ, LAST_OFF + 10'd3, '0));
        pending_accesses.push_back(mk(FUNC_WRITE, LAST_OFF + 10'd4, '1));
        pending_accesses.push_back(mk(FUNC_READ, 10'h3FF, '0));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pending_accesses.push_back(random_access());
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_accesses.size() != 0 || req_ch.valid
                   || expected_responses.size() != 0);
        repeat (10) @(negedge i_clk);

        if (error_count == 0 && expected_responses.size() == 0) begin
            $display("clock_reset_control_registers verification clean");
        end else begin
            $display("clock_reset_control_registers verification failed");
        end
        $finish;
    end

endmodule
